// ===== design/assert_macros.svh =====
// Assertion macros shared by the execute block; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BRME_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BRME_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/brme_pkg.sv =====
// Shared types, codes and helper functions of the byte register machine execute block.
package brme_pkg;

    localparam int REGS_DEFAULT      = 32;
    localparam int MEM_BYTES_DEFAULT = 512;

    localparam int OPER_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 9;
    localparam int STEP_W     = 9;
    localparam int KIND_W     = 2;
    localparam int ACT_W      = 6;
    localparam int MSIZE_W    = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam int REG_LIM_W  = 9;
    localparam int MEM_LIM_W  = 17;
    localparam int QDEPTH     = 2;
    localparam int QAW        = $clog2(QDEPTH);

    localparam logic [OPER_W-1:0] OPER_EXEC  = 3'd0;
    localparam logic [OPER_W-1:0] OPER_WRREG = 3'd1;
    localparam logic [OPER_W-1:0] OPER_WRMEM = 3'd2;
    localparam logic [OPER_W-1:0] OPER_RDREG = 3'd3;
    localparam logic [OPER_W-1:0] OPER_RDMEM = 3'd4;

    localparam logic [BYTE_W-1:0] OPC_AND    = 8'd0;
    localparam logic [BYTE_W-1:0] OPC_OR     = 8'd1;
    localparam logic [BYTE_W-1:0] OPC_ADD    = 8'd2;
    localparam logic [BYTE_W-1:0] OPC_MUL    = 8'd3;
    localparam logic [BYTE_W-1:0] OPC_XOR    = 8'd4;
    localparam logic [BYTE_W-1:0] OPC_PRINT  = 8'd5;
    localparam logic [BYTE_W-1:0] OPC_SLEEP  = 8'd6;
    localparam logic [BYTE_W-1:0] OPC_LOAD   = 8'd7;
    localparam logic [BYTE_W-1:0] OPC_STORE  = 8'd8;
    localparam logic [BYTE_W-1:0] OPC_JNE    = 8'd9;
    localparam logic [BYTE_W-1:0] OPC_LOADI  = 8'd10;
    localparam logic [BYTE_W-1:0] OPC_STOREI = 8'd11;

    localparam logic [KIND_W-1:0] EV_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] EV_PRINT = 2'd1;
    localparam logic [KIND_W-1:0] EV_SLEEP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_REGISTERS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_SIZE      = 1'd1;

    localparam logic [ACT_W-1:0]   ACTIVE_RESET = 6'd32;
    localparam logic [MSIZE_W-1:0] MSIZE_RESET  = 10'd512;
    localparam logic [STEP_W-1:0]  STEP_ONE     = 9'd1;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_ALU,
        UOP_EVENT,
        UOP_LOAD,
        UOP_STORE,
        UOP_JNE,
        UOP_REGW,
        UOP_MEMW,
        UOP_RDREG,
        UOP_RDMEM
    } uop_kind_t;

    typedef enum logic [2:0] {
        ALU_AND = 3'd0,
        ALU_OR  = 3'd1,
        ALU_ADD = 3'd2,
        ALU_MUL = 3'd3,
        ALU_XOR = 3'd4
    } alu_t;

    typedef struct packed {
        uop_kind_t          kind;
        alu_t               alu;
        logic [KIND_W-1:0]  ev_kind;
        logic [ADDR_W-1:0]  s_idx;
        logic               s_ok;
        logic [ADDR_W-1:0]  t_idx;
        logic               t_ok;
        logic [ADDR_W-1:0]  w_idx;
        logic               w_ok;
        logic [ADDR_W-1:0]  m_addr;
        logic               m_ok;
        logic [BYTE_W-1:0]  imm;
        logic [BYTE_W-1:0]  offset;
    } uop_t;

    function automatic logic reg_ok(input logic [ADDR_W-1:0] idx,
                                    input logic [ACT_W-1:0] act,
                                    input logic [REG_LIM_W-1:0] lim);
        reg_ok = (idx < {{(ADDR_W-ACT_W){1'b0}}, act}) && (idx < lim);
    endfunction

    function automatic logic mem_ok(input logic [ADDR_W-1:0] addr,
                                    input logic [MSIZE_W-1:0] msize,
                                    input logic [MEM_LIM_W-1:0] lim);
        mem_ok = ({{(MSIZE_W-ADDR_W){1'b0}}, addr} < msize)
              && ({{(MEM_LIM_W-ADDR_W){1'b0}}, addr} < lim);
    endfunction

endpackage

// ===== design/byte_register_machine_execute.sv =====
// Top level of the byte register machine execute block: configuration, decoder, queue, execute unit.
//
// Channel  Direction  Handshake             Contents
// in       input      in_valid / in_ready   operation, opcode, operands, access_address/data
// out      output     out_valid / out_ready pc_step, event_kind, event_value, read_data
// cfg      input      cfg_write             cfg_index, cfg_data
//
// The execute unit reads the register file in ISSUE and computes and writes back in EXEC; a LOAD
// reads the data memory from EXEC and writes back in LOAD. The write back waits for a free output register.
// After reset a clearing pass zeroes the data memory, with in_ready low.
// A two-word queue and the output register let the input and output sides stall on their own.
`include "assert_macros.svh"

module byte_register_machine_execute #(
    parameter int REGS      = brme_pkg::REGS_DEFAULT,
    parameter int MEM_BYTES = brme_pkg::MEM_BYTES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [brme_pkg::OPER_W-1:0]         operation,
    input  logic [brme_pkg::BYTE_W-1:0]         opcode,
    input  logic [brme_pkg::BYTE_W-1:0]         first_operand,
    input  logic [brme_pkg::BYTE_W-1:0]         second_operand,
    input  logic [brme_pkg::BYTE_W-1:0]         third_operand,
    input  logic [brme_pkg::ADDR_W-1:0]         access_address,
    input  logic [brme_pkg::BYTE_W-1:0]         access_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [brme_pkg::STEP_W-1:0]         pc_step,
    output logic [brme_pkg::KIND_W-1:0]         event_kind,
    output logic [brme_pkg::BYTE_W-1:0]         event_value,
    output logic [brme_pkg::BYTE_W-1:0]         read_data,
    input  logic                                cfg_write,
    input  logic [brme_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [brme_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [brme_pkg::ACT_W-1:0]    active_reg;
    logic [brme_pkg::MSIZE_W-1:0]  msize_reg;
    logic                          q_push;
    logic                          q_full;
    logic                          q_pop;
    logic                          q_empty;
    brme_pkg::uop_t                q_in;
    brme_pkg::uop_t                q_out;
    logic                          clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= brme_pkg::ACTIVE_RESET;
            msize_reg  <= brme_pkg::MSIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                brme_pkg::CFG_ACTIVE_REGISTERS: active_reg <= cfg_data[brme_pkg::ACT_W-1:0];
                brme_pkg::CFG_MEMORY_SIZE:      msize_reg  <= cfg_data;
                default:                        msize_reg  <= msize_reg;
            endcase
        end
    end

    brme_front #(
        .REGS      (REGS),
        .MEM_BYTES (MEM_BYTES)
    ) u_front (
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .opcode         (opcode),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .third_operand  (third_operand),
        .access_address (access_address),
        .access_data    (access_data),
        .active_regs    (active_reg),
        .mem_size       (msize_reg),
        .clearing       (clearing),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_in)
    );

    brme_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    brme_back #(
        .REGS      (REGS),
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .mem_size    (msize_reg),
        .q_empty     (q_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pc_step     (pc_step),
        .event_kind  (event_kind),
        .event_value (event_value),
        .read_data   (read_data)
    );

    `BRME_ASSERT_IMP(a_clear_blocks_input, clearing, !in_ready)
    `BRME_ASSERT_NXT(a_pop_spacing, q_pop, !q_pop)
    `BRME_ASSERT_IMP(a_event_no_jump, out_valid && (event_kind != brme_pkg::EV_NONE), pc_step == brme_pkg::STEP_ONE)
    `BRME_ASSERT_IMP(a_read_no_event, out_valid && (read_data != '0), (event_kind == brme_pkg::EV_NONE) && (event_value == '0))

endmodule

// ===== design/brme_queue.sv =====
// Two-word queue of decoded operations between the front decoder and the execute unit.
module brme_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  brme_pkg::uop_t push_data,
    output logic           full,
    input  logic           pop,
    output brme_pkg::uop_t pop_data,
    output logic           empty
);

    localparam int QAW = brme_pkg::QAW;
    localparam int CW  = QAW + 1;
    localparam logic [CW-1:0]  FULL_CNT = CW'(brme_pkg::QDEPTH);
    localparam logic [QAW-1:0] LAST_PTR = QAW'(brme_pkg::QDEPTH - 1);

    brme_pkg::uop_t  q_mem [brme_pkg::QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg;
    logic [QAW-1:0]  wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg;
    logic [QAW-1:0]  rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/brme_front.sv =====
// Front decoder: accepts input words and turns them into checked operations for the queue.
module brme_front #(
    parameter int REGS      = brme_pkg::REGS_DEFAULT,
    parameter int MEM_BYTES = brme_pkg::MEM_BYTES_DEFAULT
) (
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [brme_pkg::OPER_W-1:0]       operation,
    input  logic [brme_pkg::BYTE_W-1:0]       opcode,
    input  logic [brme_pkg::BYTE_W-1:0]       first_operand,
    input  logic [brme_pkg::BYTE_W-1:0]       second_operand,
    input  logic [brme_pkg::BYTE_W-1:0]       third_operand,
    input  logic [brme_pkg::ADDR_W-1:0]       access_address,
    input  logic [brme_pkg::BYTE_W-1:0]       access_data,
    input  logic [brme_pkg::ACT_W-1:0]        active_regs,
    input  logic [brme_pkg::MSIZE_W-1:0]      mem_size,
    input  logic                              clearing,
    input  logic                              q_full,
    output logic                              q_push,
    output brme_pkg::uop_t                    q_data
);

    localparam logic [brme_pkg::REG_LIM_W-1:0] REG_LIM = brme_pkg::REG_LIM_W'(REGS);
    localparam logic [brme_pkg::MEM_LIM_W-1:0] MEM_LIM = brme_pkg::MEM_LIM_W'(MEM_BYTES);

    brme_pkg::uop_t                    uop;
    logic [brme_pkg::ADDR_W-1:0]       op1_idx;
    logic [brme_pkg::ADDR_W-1:0]       op2_idx;
    logic [brme_pkg::ADDR_W-1:0]       op3_idx;

    assign op1_idx = {1'b0, first_operand};
    assign op2_idx = {1'b0, second_operand};
    assign op3_idx = {1'b0, third_operand};

    assign in_ready = !q_full && !clearing;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        uop      = '0;
        uop.kind = brme_pkg::UOP_NOP;
        uop.alu  = brme_pkg::ALU_AND;
        unique case (operation)
            brme_pkg::OPER_EXEC:
            begin
                unique case (opcode) inside
                    brme_pkg::OPC_AND, brme_pkg::OPC_OR, brme_pkg::OPC_ADD,
                    brme_pkg::OPC_MUL, brme_pkg::OPC_XOR:
                    begin
                        uop.kind  = brme_pkg::UOP_ALU;
                        uop.alu   = brme_pkg::alu_t'(opcode[2:0]);
                        uop.s_idx = op2_idx;
                        uop.t_idx = op3_idx;
                        uop.w_idx = op1_idx;
                    end
                    brme_pkg::OPC_PRINT, brme_pkg::OPC_SLEEP:
                    begin
                        uop.kind    = brme_pkg::UOP_EVENT;
                        uop.ev_kind = (opcode == brme_pkg::OPC_PRINT) ? brme_pkg::EV_PRINT
                                                                     : brme_pkg::EV_SLEEP;
                        uop.t_idx   = op1_idx;
                    end
                    brme_pkg::OPC_LOAD:
                    begin
                        uop.kind  = brme_pkg::UOP_LOAD;
                        uop.s_idx = op2_idx;
                        uop.w_idx = op1_idx;
                    end
                    brme_pkg::OPC_STORE:
                    begin
                        uop.kind  = brme_pkg::UOP_STORE;
                        uop.s_idx = op2_idx;
                        uop.t_idx = op1_idx;
                    end
                    brme_pkg::OPC_JNE:
                    begin
                        uop.kind   = brme_pkg::UOP_JNE;
                        uop.s_idx  = op2_idx;
                        uop.t_idx  = op1_idx;
                        uop.offset = third_operand;
                    end
                    brme_pkg::OPC_LOADI:
                    begin
                        uop.kind  = brme_pkg::UOP_REGW;
                        uop.w_idx = op1_idx;
                        uop.imm   = second_operand;
                    end
                    brme_pkg::OPC_STOREI:
                    begin
                        uop.kind   = brme_pkg::UOP_MEMW;
                        uop.m_addr = op1_idx;
                        uop.imm    = second_operand;
                    end
                    default:
                    begin
                        uop.kind = brme_pkg::UOP_NOP;
                    end
                endcase
            end
            brme_pkg::OPER_WRREG:
            begin
                uop.kind  = brme_pkg::UOP_REGW;
                uop.w_idx = access_address;
                uop.imm   = access_data;
            end
            brme_pkg::OPER_WRMEM:
            begin
                uop.kind   = brme_pkg::UOP_MEMW;
                uop.m_addr = access_address;
                uop.imm    = access_data;
            end
            brme_pkg::OPER_RDREG:
            begin
                uop.kind  = brme_pkg::UOP_RDREG;
                uop.s_idx = access_address;
            end
            brme_pkg::OPER_RDMEM:
            begin
                uop.kind   = brme_pkg::UOP_RDMEM;
                uop.m_addr = access_address;
            end
            default:
            begin
                uop.kind = brme_pkg::UOP_NOP;
            end
        endcase
        uop.s_ok = brme_pkg::reg_ok(uop.s_idx, active_regs, REG_LIM);
        uop.t_ok = brme_pkg::reg_ok(uop.t_idx, active_regs, REG_LIM);
        uop.w_ok = brme_pkg::reg_ok(uop.w_idx, active_regs, REG_LIM);
        uop.m_ok = brme_pkg::mem_ok(uop.m_addr, mem_size, MEM_LIM);
    end

    assign q_data = uop;

endmodule

// ===== design/brme_back.sv =====
// Execute unit: register file, data memory, clearing pass and the output register.
module brme_back #(
    parameter int REGS      = brme_pkg::REGS_DEFAULT,
    parameter int MEM_BYTES = brme_pkg::MEM_BYTES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [brme_pkg::MSIZE_W-1:0]      mem_size,
    input  logic                              q_empty,
    input  brme_pkg::uop_t                    q_data,
    output logic                              q_pop,
    output logic                              clearing,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [brme_pkg::STEP_W-1:0]       pc_step,
    output logic [brme_pkg::KIND_W-1:0]       event_kind,
    output logic [brme_pkg::BYTE_W-1:0]       event_value,
    output logic [brme_pkg::BYTE_W-1:0]       read_data
);

    localparam int BW  = brme_pkg::BYTE_W;
    localparam int RAW = (REGS > 1) ? $clog2(REGS) : 1;
    localparam int MAW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
    localparam logic [MAW-1:0] CLR_LAST = MAW'(MEM_BYTES - 1);
    localparam logic [brme_pkg::MEM_LIM_W-1:0] MEM_LIM = brme_pkg::MEM_LIM_W'(MEM_BYTES);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_LOAD  = 4'b1000
    } back_state_t;

    back_state_t                     state_reg;
    back_state_t                     state_next;
    logic [MAW-1:0]                  clr_cnt_reg;
    logic [MAW-1:0]                  clr_cnt_next;
    brme_pkg::uop_t                  uop_reg;

    logic [BW-1:0]                   rf_mem [REGS];
    logic [REGS-1:0]                 rf_vld_reg;
    logic [BW-1:0]                   s_raw_reg;
    logic [BW-1:0]                   t_raw_reg;
    logic                            s_vld_reg;
    logic                            t_vld_reg;
    logic [BW-1:0]                   s_val;
    logic [BW-1:0]                   t_val;
    logic                            rf_we;
    logic [RAW-1:0]                  rf_widx;
    logic [BW-1:0]                   rf_wdata;

    logic [BW-1:0]                   mem_arr [MEM_BYTES];
    logic [BW-1:0]                   m_rdata_reg;
    logic                            mem_we;
    logic [MAW-1:0]                  mem_widx;
    logic [BW-1:0]                   mem_wdata;
    logic                            mem_re;
    logic [MAW-1:0]                  mem_ridx;

    logic [2*BW-1:0]                 prod;
    logic [BW-1:0]                   alu_res;
    logic                            ld_ok;
    logic                            st_ok;
    logic                            out_free;
    logic                            finish;

    logic                            out_valid_reg;
    logic [brme_pkg::STEP_W-1:0]     pc_step_reg;
    logic [brme_pkg::STEP_W-1:0]     pc_step_next;
    logic [brme_pkg::KIND_W-1:0]     event_kind_reg;
    logic [brme_pkg::KIND_W-1:0]     event_kind_next;
    logic [BW-1:0]                   event_value_reg;
    logic [BW-1:0]                   event_value_next;
    logic [BW-1:0]                   read_data_reg;
    logic [BW-1:0]                   read_data_next;

    assign clearing = (state_reg == ST_CLEAR);
    assign s_val    = s_vld_reg ? s_raw_reg : '0;
    assign t_val    = t_vld_reg ? t_raw_reg : '0;
    assign prod     = s_val * t_val;
    assign ld_ok    = brme_pkg::mem_ok({1'b0, s_val}, mem_size, MEM_LIM);
    assign st_ok    = brme_pkg::mem_ok({1'b0, t_val}, mem_size, MEM_LIM);
    assign out_free = !out_valid_reg || out_ready;
    assign rf_widx  = RAW'(uop_reg.w_idx);

    always_comb
    begin
        unique case (uop_reg.alu)
            brme_pkg::ALU_AND: alu_res = s_val & t_val;
            brme_pkg::ALU_OR:  alu_res = s_val | t_val;
            brme_pkg::ALU_ADD: alu_res = s_val + t_val;
            brme_pkg::ALU_MUL: alu_res = prod[BW-1:0];
            brme_pkg::ALU_XOR: alu_res = s_val ^ t_val;
            default:           alu_res = '0;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        q_pop        = 1'b0;
        finish       = 1'b0;
        rf_we        = 1'b0;
        rf_wdata     = '0;
        mem_we       = 1'b0;
        mem_widx     = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_ridx     = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_widx = clr_cnt_reg;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_ISSUE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_ISSUE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_EXEC;
                    if (q_data.kind == brme_pkg::UOP_RDMEM)
                    begin
                        mem_re   = 1'b1;
                        mem_ridx = MAW'(q_data.m_addr);
                    end
                end
            end
            ST_EXEC:
            begin
                if (uop_reg.kind == brme_pkg::UOP_LOAD)
                begin
                    mem_re     = 1'b1;
                    mem_ridx   = MAW'({1'b0, s_val});
                    state_next = ST_LOAD;
                end
                else if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = ST_ISSUE;
                    case (uop_reg.kind)
                        brme_pkg::UOP_ALU:
                        begin
                            rf_we    = uop_reg.w_ok;
                            rf_wdata = alu_res;
                        end
                        brme_pkg::UOP_REGW:
                        begin
                            rf_we    = uop_reg.w_ok;
                            rf_wdata = uop_reg.imm;
                        end
                        brme_pkg::UOP_STORE:
                        begin
                            mem_we    = st_ok;
                            mem_widx  = MAW'({1'b0, t_val});
                            mem_wdata = s_val;
                        end
                        brme_pkg::UOP_MEMW:
                        begin
                            mem_we    = uop_reg.m_ok;
                            mem_widx  = MAW'(uop_reg.m_addr);
                            mem_wdata = uop_reg.imm;
                        end
                        default:
                        begin
                            rf_we = 1'b0;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = ST_ISSUE;
                    rf_we      = uop_reg.w_ok && ld_ok;
                    rf_wdata   = m_rdata_reg;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        pc_step_next     = brme_pkg::STEP_ONE;
        event_kind_next  = brme_pkg::EV_NONE;
        event_value_next = '0;
        read_data_next   = '0;
        case (uop_reg.kind)
            brme_pkg::UOP_EVENT:
            begin
                event_kind_next  = uop_reg.ev_kind;
                event_value_next = t_val;
            end
            brme_pkg::UOP_JNE:
            begin
                if (t_val != s_val)
                begin
                    pc_step_next = brme_pkg::STEP_ONE + {1'b0, uop_reg.offset};
                end
            end
            brme_pkg::UOP_RDREG:
            begin
                read_data_next = s_val;
            end
            brme_pkg::UOP_RDMEM:
            begin
                read_data_next = uop_reg.m_ok ? m_rdata_reg : '0;
            end
            default:
            begin
                read_data_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_widx] <= rf_wdata;
        end
        if (q_pop)
        begin
            s_raw_reg <= rf_mem[RAW'(q_data.s_idx)];
            t_raw_reg <= rf_mem[RAW'(q_data.t_idx)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_arr[mem_widx] <= mem_wdata;
        end
        if (mem_re)
        begin
            m_rdata_reg <= mem_arr[mem_ridx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            uop_reg <= q_data;
        end
        if (finish)
        begin
            pc_step_reg     <= pc_step_next;
            event_kind_reg  <= event_kind_next;
            event_value_reg <= event_value_next;
            read_data_reg   <= read_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rf_vld_reg    <= '0;
            s_vld_reg     <= 1'b0;
            t_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (rf_we)
            begin
                rf_vld_reg[rf_widx] <= 1'b1;
            end
            if (q_pop)
            begin
                s_vld_reg <= q_data.s_ok && rf_vld_reg[RAW'(q_data.s_idx)];
                t_vld_reg <= q_data.t_ok && rf_vld_reg[RAW'(q_data.t_idx)];
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign pc_step     = pc_step_reg;
    assign event_kind  = event_kind_reg;
    assign event_value = event_value_reg;
    assign read_data   = read_data_reg;

endmodule
